// ----- rtl/shc_pkg.sv -----
package shc_pkg;

	localparam logic [1:0] CLASS_COLD    = 2'd0;
	localparam logic [1:0] CLASS_COMFORT = 2'd1;
	localparam logic [1:0] CLASS_HOT     = 2'd2;

	localparam logic [1:0] HEALTH_NORMAL = 2'd0;
	localparam logic [1:0] HEALTH_CHECK  = 2'd1;
	localparam logic [1:0] HEALTH_WARN   = 2'd2;

	localparam logic [2:0] REG_COLD_TEMP_LIMIT  = 3'd0;
	localparam logic [2:0] REG_HOT_TEMP_LIMIT   = 3'd1;
	localparam logic [2:0] REG_DRY_HUM_LIMIT    = 3'd2;
	localparam logic [2:0] REG_HUMID_HUM_LIMIT  = 3'd3;
	localparam logic [2:0] REG_WARN_RUN_LIMIT   = 3'd4;
	localparam logic [2:0] REG_WARN_COUNT_LIMIT = 3'd5;
	localparam logic [2:0] REG_CHECK_COUNT_MAX  = 3'd6;
	localparam logic [2:0] REG_VOTE_MIN         = 3'd7;

	typedef struct packed {
		logic [9:0] filtered_temp;
		logic [9:0] filtered_hum;
		logic       anomaly_flag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  health_state;
		logic [4:0]  window_anomalies;
		logic [7:0]  anomaly_run;
		logic [1:0]  comfort_class;
		logic [31:0] sample_total;
		logic [31:0] anomaly_total;
	} out_item_t;

	typedef struct packed {
		logic [9:0] cold_temp_limit;
		logic [9:0] hot_temp_limit;
		logic [9:0] dry_hum_limit;
		logic [9:0] humid_hum_limit;
		logic [7:0] warn_run_limit;
		logic [4:0] warn_count_limit;
		logic [4:0] check_count_max;
		logic [2:0] vote_min;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cold_temp_limit:  10'd240,
		hot_temp_limit:   10'd280,
		dry_hum_limit:    10'd350,
		humid_hum_limit:  10'd750,
		warn_run_limit:   8'd5,
		warn_count_limit: 5'd20,
		check_count_max:  5'd5,
		vote_min:         3'd3
	};

	// Health and counter results of the flag tracker for one transaction.
	typedef struct packed {
		logic [1:0]  health_state;
		logic [4:0]  window_anomalies;
		logic [7:0]  anomaly_run;
		logic [31:0] sample_total;
		logic [31:0] anomaly_total;
	} flag_res_t;

endpackage

// ----- rtl/sensor_health_and_comfort_classifier.sv -----
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_data (in_item_t)
// out      output     out_valid/out_stall out_data (out_item_t)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A sample is taken into an input register, evaluated combinationally and lands in the
// output register, which holds the result until the output is taken.
// One sample is accepted per cycle; throughput is limited only by out_stall.
// Reset returns all windows, counters, the configuration and the valid flags to their initial values at once.
// A held output stalls the input register, which in turn raises in_stall.
module sensor_health_and_comfort_classifier
	import shc_pkg::*;
#(
	parameter int FLAG_WINDOW = 30,
	parameter int VOTE_WINDOW = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;
	logic      advance;
	logic      fire;
	logic      accept;
	flag_res_t flag_res;
	logic [1:0] comfort_class;

	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COLD_TEMP_LIMIT:  cfg_q.cold_temp_limit  <= cfg_data;
				REG_HOT_TEMP_LIMIT:   cfg_q.hot_temp_limit   <= cfg_data;
				REG_DRY_HUM_LIMIT:    cfg_q.dry_hum_limit    <= cfg_data;
				REG_HUMID_HUM_LIMIT:  cfg_q.humid_hum_limit  <= cfg_data;
				REG_WARN_RUN_LIMIT:   cfg_q.warn_run_limit   <= cfg_data[7:0];
				REG_WARN_COUNT_LIMIT: cfg_q.warn_count_limit <= cfg_data[4:0];
				REG_CHECK_COUNT_MAX:  cfg_q.check_count_max  <= cfg_data[4:0];
				REG_VOTE_MIN:         cfg_q.vote_min         <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	shc_flag_track #(
		.FLAG_WINDOW(FLAG_WINDOW)
	) u_flag_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.anomaly_flag (item_s1.anomaly_flag),
		.cfg          (cfg_q),
		.res          (flag_res)
	);

	shc_vote #(
		.VOTE_WINDOW(VOTE_WINDOW)
	) u_vote (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.cfg           (cfg_q),
		.comfort_class (comfort_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.health_state     <= flag_res.health_state;
			out_q.window_anomalies <= flag_res.window_anomalies;
			out_q.anomaly_run      <= flag_res.anomaly_run;
			out_q.comfort_class    <= comfort_class;
			out_q.sample_total     <= flag_res.sample_total;
			out_q.anomaly_total    <= flag_res.anomaly_total;
		end
	end

endmodule

// ----- rtl/shc_flag_track.sv -----
module shc_flag_track
	import shc_pkg::*;
#(
	parameter int FLAG_WINDOW = 30
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  logic      anomaly_flag,
	input  cfg_t      cfg,
	output flag_res_t res
);

	localparam int CNTW = $clog2(FLAG_WINDOW + 1);

	logic [FLAG_WINDOW-1:0] hist_q;
	logic [FLAG_WINDOW-1:0] hist_d;
	logic [CNTW-1:0]        count_q;
	logic [CNTW-1:0]        count_d;
	logic [7:0]             run_q;
	logic [7:0]             run_d;
	logic [31:0]            samples_q;
	logic [31:0]            samples_d;
	logic [31:0]            anoms_q;
	logic [31:0]            anoms_d;
	logic                   oldest;

	// The window is a shift line; the bit leaving it is the oldest flag.
	assign oldest = hist_q[FLAG_WINDOW-1];
	assign hist_d = (hist_q << 1) | FLAG_WINDOW'(anomaly_flag);
	assign count_d = count_q + CNTW'(anomaly_flag) - CNTW'(oldest);

	always_comb begin
		if (!anomaly_flag) begin
			run_d = 8'd0;
		end else if (run_q == 8'hFF) begin
			run_d = run_q;
		end else begin
			run_d = run_q + 8'd1;
		end
	end

	assign samples_d = (samples_q == 32'hFFFF_FFFF) ? samples_q : samples_q + 32'd1;
	assign anoms_d = (anomaly_flag && anoms_q != 32'hFFFF_FFFF) ? anoms_q + 32'd1 : anoms_q;

	always_comb begin
		if (run_d >= cfg.warn_run_limit || 8'(count_d) > 8'(cfg.warn_count_limit)) begin
			res.health_state = HEALTH_WARN;
		end else if (count_d != '0 && 8'(count_d) <= 8'(cfg.check_count_max)) begin
			res.health_state = HEALTH_CHECK;
		end else begin
			res.health_state = HEALTH_NORMAL;
		end
		res.window_anomalies = (8'(count_d) > 8'd31) ? 5'd31 : 5'(count_d);
		res.anomaly_run      = run_d;
		res.sample_total     = samples_d;
		res.anomaly_total    = anoms_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= '0;
			count_q   <= '0;
			run_q     <= '0;
			samples_q <= '0;
			anoms_q   <= '0;
		end else if (fire) begin
			hist_q    <= hist_d;
			count_q   <= count_d;
			run_q     <= run_d;
			samples_q <= samples_d;
			anoms_q   <= anoms_d;
		end
	end

endmodule

// ----- rtl/shc_vote.sv -----
module shc_vote
	import shc_pkg::*;
#(
	parameter int VOTE_WINDOW = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_item_t   item,
	input  cfg_t       cfg,
	output logic [1:0] comfort_class
);

	localparam int CW = $clog2(VOTE_WINDOW + 1);

	logic [1:0]    hist_q [VOTE_WINDOW];
	logic [CW-1:0] cnt_q  [3];
	logic [CW-1:0] cnt_d  [3];
	logic [1:0]    kept_q;
	logic [1:0]    kept_d;
	logic [1:0]    cls;
	logic [1:0]    oldest;
	logic [1:0]    best;
	logic [CW-1:0] best_n;
	logic          push;

	assign push   = fire && !item.anomaly_flag;
	assign oldest = hist_q[VOTE_WINDOW-1];

	always_comb begin
		if (item.filtered_temp < cfg.cold_temp_limit) begin
			cls = CLASS_COLD;
		end else if (item.filtered_temp > cfg.hot_temp_limit) begin
			cls = CLASS_HOT;
		end else if (item.filtered_hum < cfg.dry_hum_limit) begin
			cls = CLASS_COLD;
		end else if (item.filtered_hum > cfg.humid_hum_limit) begin
			cls = CLASS_HOT;
		end else begin
			cls = CLASS_COMFORT;
		end
	end

	// Running per-class counts stand in for a scan of the history.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cnt_d[k] = cnt_q[k] - CW'(oldest == 2'(k)) + CW'(cls == 2'(k));
		end
	end

	// Ties go to the earlier class: cold, then comfort, then hot.
	always_comb begin
		best   = CLASS_COLD;
		best_n = cnt_d[0];
		if (cnt_d[1] > best_n) begin
			best   = CLASS_COMFORT;
			best_n = cnt_d[1];
		end
		if (cnt_d[2] > best_n) begin
			best   = CLASS_HOT;
			best_n = cnt_d[2];
		end
		if (best != kept_q && 8'(best_n) >= 8'(cfg.vote_min)) begin
			kept_d = best;
		end else begin
			kept_d = kept_q;
		end
	end

	assign comfort_class = item.anomaly_flag ? kept_q : kept_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOTE_WINDOW; i++) begin
				hist_q[i] <= CLASS_COMFORT;
			end
			cnt_q[0] <= '0;
			cnt_q[1] <= CW'(VOTE_WINDOW);
			cnt_q[2] <= '0;
			kept_q   <= CLASS_COMFORT;
		end else if (push) begin
			for (int i = 1; i < VOTE_WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= cls;
			for (int k = 0; k < 3; k++) begin
				cnt_q[k] <= cnt_d[k];
			end
			kept_q <= kept_d;
		end
	end

endmodule
